[sv/ess_pkg.sv]
`timescale 1ns / 1ps

package ess_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W   = 3;
    localparam int ROWIDX_W = 8;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 32;
    localparam int SPR_W    = 4;

    // One slot in the row-wide data memory: column tag above the value.
    localparam int ENTRY_W = COL_W + VAL_W;

    // Operation codes.
    localparam logic [FUNC_W-1:0] F_READ  = 3'd0;
    localparam logic [FUNC_W-1:0] F_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] F_ADD   = 3'd2;
    localparam logic [FUNC_W-1:0] F_SCALE = 3'd3;
    localparam logic [FUNC_W-1:0] F_UNIT  = 3'd4;
    localparam logic [FUNC_W-1:0] F_CLEAR = 3'd5;

    // Q16.16 one.
    localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;

    // Reset value of the slots-per-row register.
    localparam logic [SPR_W-1:0] SPR_RESET = 4'd8;

    // Outcome of the slot search over one row.
    typedef struct packed {
        logic hit;    // a valid in-use slot carries the requested tag
        logic avail;  // a slot can take the entry (hit or free)
    } search_t;

endpackage

[sv/ess_ram.sv]
`timescale 1ns / 1ps

module ess_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/ess_slot_search.sv]
`timescale 1ns / 1ps

module ess_slot_search #(
    parameter int SLOTS = 8,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0]                  valid_word,
    input  logic [SLOTS*ess_pkg::ENTRY_W-1:0] data_word,
    input  logic [ess_pkg::COL_W-1:0]         col,
    input  logic [ess_pkg::SPR_W-1:0]         spr,
    output ess_pkg::search_t                  res,
    output logic [SLOT_W-1:0]                 slot,
    output logic [ess_pkg::VAL_W-1:0]         old_value
);

    import ess_pkg::*;

    logic [SLOTS-1:0]  in_use;
    logic              match_found;
    logic [SLOT_W-1:0] match_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    // Slot 0 is always in use; above it the register sets the count, and
    // the built slot count caps it on its own.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            in_use[i] = (i == 0) || (7'(i) < 7'(spr));
        end
    end

    // The first matching slot wins, so scan from the top down.
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (in_use[i] && valid_word[i] &&
                data_word[i*ENTRY_W+VAL_W +: COL_W] == col)
            begin
                match_found = 1'b1;
                match_idx   = SLOT_W'(i);
            end
        end
    end

    // The last free slot wins, so scan from the bottom up.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (in_use[i] && !valid_word[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign res.hit   = match_found;
    assign res.avail = match_found || free_found;
    assign slot      = match_found ? match_idx : free_idx;
    assign old_value = data_word[match_idx*ENTRY_W +: VAL_W];

endmodule

[sv/ess_value_unit.sv]
`timescale 1ns / 1ps

module ess_value_unit (
    input  logic                      clk,
    input  logic                      mul_en,
    input  logic [ess_pkg::VAL_W-1:0] old_value,
    input  logic [ess_pkg::VAL_W-1:0] operand,
    output logic [ess_pkg::VAL_W-1:0] sum_value,
    output logic [ess_pkg::VAL_W-1:0] scaled_value
);

    import ess_pkg::*;

    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [2*VAL_W-1:0] prod_next;
    logic signed [2*VAL_W-1:0] prod_adj;
    logic signed [2*VAL_W-1:0] quot;
    logic        [VAL_W:0]     sum_wide;

    // Saturating add of two Q16.16 values.
    assign sum_wide  = {old_value[VAL_W-1], old_value} + {operand[VAL_W-1], operand};
    assign sum_value = (sum_wide[VAL_W] == sum_wide[VAL_W-1]) ? sum_wide[VAL_W-1:0] :
                       (sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} :
                                          {1'b0, {(VAL_W-1){1'b1}}});

    // The full product is registered before the shift and saturation.
    assign prod_next = $signed(old_value) * $signed(operand);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Negative products are biased up so the arithmetic shift truncates
    // toward zero.
    assign prod_adj = prod_reg + (prod_reg[2*VAL_W-1] ? 64'sh0000_0000_0000_FFFF : 64'sh0);
    assign quot     = prod_adj >>> 16;

    assign scaled_value = (&quot[2*VAL_W-1:VAL_W-1] || ~|quot[2*VAL_W-1:VAL_W-1]) ?
                          quot[VAL_W-1:0] :
                          (quot[2*VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} :
                                             {1'b0, {(VAL_W-1){1'b1}}});

endmodule

[sv/ell_sparse_entry_store.sv]
`timescale 1ns / 1ps

// Sparse matrix store in ELLPACK form. Every row owns SLOTS slots, each with
// a column tag, a valid mark and a Q16.16 value; a row lives in one word of a
// row-wide data memory and one word of a valid-mask memory, so an operation
// is a single read of the row, a parallel tag search across its slots and a
// single write back. An operation is accepted when start is high and busy is
// low. Read, set, add and unit row pass through the look and execute states
// and return to idle, with the result strobed on done in the first cycle in
// which busy is low again; scale adds a further state after execute for the
// registered 32x32 multiplier. Clear all sweeps the valid memory one row per
// cycle and then strobes done. After reset the same sweep runs with busy
// high before the first operation can be accepted; configuration writes are
// taken at any time. Every operation gives exactly one result beat, and the
// receiver cannot stall it: read_value and status are valid only in the
// cycle in which done is high. The slots_per_row register sits at byte
// address 0 and should be written only while the block is idle.

module ell_sparse_entry_store #(
    parameter int ROWS    = 256,
    parameter int SLOTS   = 8,
    parameter int COLUMNS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic [ess_pkg::FUNC_W-1:0]   func,
    input  logic [ess_pkg::ROWIDX_W-1:0] row_index,
    input  logic [ess_pkg::COL_W-1:0]    col_index,
    input  logic signed [ess_pkg::VAL_W-1:0] operand_value,

    output logic                         done,
    output logic signed [ess_pkg::VAL_W-1:0] read_value,
    output logic                         status,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import ess_pkg::*;

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W = SLOTS * ENTRY_W;

    // Control states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ROW_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                clr_reply_reg, clr_reply_next;
    logic                done_reg, done_next;
    logic [VAL_W-1:0]    read_value_reg, read_value_next;
    logic                status_reg, status_next;
    logic [SPR_W-1:0]    spr_reg;

    // Captured operation and search outcome; payload, no reset.
    logic [FUNC_W-1:0]   func_reg;
    logic [ROWIDX_W-1:0] row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [VAL_W-1:0]    opv_reg;
    logic                row_oob_reg;
    logic                col_oob_reg;
    search_t             srch_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [VAL_W-1:0]    old_reg;

    logic                accept;
    logic [ROW_W-1:0]    row_addr;
    logic [WORD_W-1:0]   data_rdata, data_wdata;
    logic [SLOTS-1:0]    valid_rdata, valid_wdata;
    logic                data_we, valid_we;
    logic [ROW_W-1:0]    valid_waddr;
    logic                wr_en;
    logic [VAL_W-1:0]    new_value;

    search_t             srch;
    logic [SLOT_W-1:0]   srch_slot;
    logic [VAL_W-1:0]    srch_old;
    logic [VAL_W-1:0]    sum_value, scaled_value;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign row_addr = ROW_W'(row_index);

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : {28'h0, spr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            spr_reg <= pwdata[SPR_W-1:0];
        end
    end

    // Row memories: tags and values in one, valid masks in the other.
    ess_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (ROW_W'(row_reg)),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (row_addr),
        .rdata (data_rdata)
    );

    ess_ram #(.WIDTH(SLOTS), .DEPTH(ROWS)) u_valid_ram (
        .clk   (clk),
        .we    (valid_we),
        .waddr (valid_waddr),
        .wdata (valid_wdata),
        .re    (accept),
        .raddr (row_addr),
        .rdata (valid_rdata)
    );

    ess_slot_search #(.SLOTS(SLOTS)) u_search (
        .valid_word (valid_rdata),
        .data_word  (data_rdata),
        .col        (col_reg),
        .spr        (spr_reg),
        .res        (srch),
        .slot       (srch_slot),
        .old_value  (srch_old)
    );

    ess_value_unit u_value (
        .clk          (clk),
        .mul_en       (state_reg == ST_EXEC),
        .old_value    (srch_reg.hit ? old_reg : '0),
        .operand      (opv_reg),
        .sum_value    (sum_value),
        .scaled_value (scaled_value)
    );

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            row_reg     <= row_index;
            col_reg     <= col_index;
            opv_reg     <= operand_value;
            row_oob_reg <= !(17'(row_index) < 17'(ROWS));
            col_oob_reg <= !(17'(col_index) < 17'(COLUMNS));
        end
        if (state_reg == ST_LOOK)
        begin
            srch_reg <= srch;
            slot_reg <= srch_slot;
            old_reg  <= srch_old;
        end
    end

    // Value written into the chosen slot.
    always_comb
    begin
        unique case (func_reg)
            F_ADD:   new_value = sum_value;
            F_SCALE: new_value = scaled_value;
            default: new_value = opv_reg;
        endcase
    end

    // Write-back word: unit row rewrites slot 0 and leaves only it valid;
    // the other operations replace the chosen slot and set its mark.
    always_comb
    begin
        data_wdata = data_rdata;
        if (func_reg == F_UNIT)
        begin
            data_wdata[0 +: ENTRY_W] = {COL_W'(row_reg), Q_ONE};
            valid_wdata = SLOTS'(1);
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_reg == SLOT_W'(i))
                begin
                    data_wdata[i*ENTRY_W +: ENTRY_W] = {col_reg, new_value};
                end
            end
            valid_wdata = valid_rdata | (SLOTS'(1) << slot_reg);
        end
        if (state_reg == ST_CLEAR)
        begin
            valid_wdata = '0;
        end
    end

    assign data_we     = wr_en;
    assign valid_we    = wr_en || (state_reg == ST_CLEAR);
    assign valid_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : ROW_W'(row_reg);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        done_next       = 1'b0;
        read_value_next = '0;
        status_next     = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next   = ST_IDLE;
                    clr_cnt_next = '0;
                    done_next    = clr_reply_reg;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == F_CLEAR)
                    begin
                        state_next     = ST_CLEAR;
                        clr_cnt_next   = '0;
                        clr_reply_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                // Out-of-range rows and unused codes change nothing.
                if (!row_oob_reg && func_reg <= F_UNIT)
                begin
                    priority if (func_reg == F_UNIT)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (col_oob_reg)
                    begin
                        wr_en = 1'b0;
                    end
                    else if (func_reg == F_READ)
                    begin
                        read_value_next = srch_reg.hit ? old_reg : '0;
                    end
                    else if (func_reg == F_SET && opv_reg == '0)
                    begin
                        wr_en = 1'b0;
                    end
                    else if (!srch_reg.avail)
                    begin
                        status_next = 1'b1;
                    end
                    else if (func_reg == F_SCALE)
                    begin
                        state_next = ST_SCALE;
                        done_next  = 1'b0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                wr_en      = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule
